[design/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, codes and constants of the tap tempo estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

  // Interval window; sum holds a full window of 2999 ms intervals
  localparam int WINDOW_DEPTH = 8;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int IV_W         = 12;
  localparam int SUM_W        = $clog2(WINDOW_DEPTH * 2999 + 1);

  // Interval limits and tempo numerator (60 s * 100 centi-BPM * 1000 ms)
  localparam logic [31:0] MIN_IV_MS  = 32'd100;
  localparam logic [31:0] MAX_IV_MS  = 32'd3000;
  localparam logic [31:0] TEMPO_NUM  = 32'd6000000;

  // Shared divider sizes
  localparam int DIV_W   = 32;
  localparam int DSR_W   = 12;
  localparam int DCNT_W  = $clog2(DIV_W);

  // Command codes
  localparam logic [1:0] OP_TAP    = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDLE_GAP    = 2'd0;
  localparam logic [1:0] CFG_SOLID_THR   = 2'd1;
  localparam logic [1:0] CFG_PULSE_WIDTH = 2'd2;

  // Configuration reset values
  localparam logic [15:0] IDLE_GAP_RST    = 16'd3000;
  localparam logic [3:0]  SOLID_THR_RST   = 4'd4;
  localparam logic [15:0] PULSE_WIDTH_RST = 16'd100;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        sample_stored;
    logic        window_restarted;
    logic [11:0] average_interval_ms;
    logic [15:0] tempo_centi_bpm;
    logic [3:0]  stored_count;
    logic        tempo_solid;
    logic [15:0] taps_seen;
    logic        beat_pulse;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

[design/tte_front.sv]
// ----------------------------------------------------------------------------
// tte_front
// Accepts command items and queues them in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module tte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tte_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_pop,
  output tte_pkg::in_item_t q_item
);
  import tte_pkg::*;

  in_item_t   q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = q_mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage; codes 3 are kept and ignored downstream
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[design/tte_div.sv]
// ----------------------------------------------------------------------------
// tte_div
// Restoring radix-2 divider, one quotient bit per cycle, 32 steps.
// ----------------------------------------------------------------------------
module tte_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tte_pkg::div_req_t req,
  output tte_pkg::div_rsp_t rsp
);
  import tte_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DSR_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (busy_r) begin
      // one shift-subtract step
      rem_nxt = fits ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

[design/tte_back.sv]
// ----------------------------------------------------------------------------
// tte_back
// Executes queued commands: interval window update, average and tempo
// through the shared divider, beat pulse phase, and the result register.
// ----------------------------------------------------------------------------
module tte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  tte_pkg::in_item_t  q_item,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output tte_pkg::div_req_t  div_req,
  input  tte_pkg::div_rsp_t  div_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output tte_pkg::out_item_t out_item
);
  import tte_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_AVG   = 3'd2;
  localparam logic [2:0] ST_TEMPO = 3'd3;
  localparam logic [2:0] ST_QRY   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Configuration
  logic [15:0] idle_gap_r;
  logic [3:0]  solid_thr_r;
  logic [15:0] pulse_w_r;

  // Sequencer and current item
  logic [2:0]  state_r, state_nxt;
  in_item_t    cur_r;

  // Estimator state
  logic [IV_W-1:0]   ring_r [WINDOW_DEPTH];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [31:0]       last_r, last_nxt;
  logic              tap_valid_r, tap_valid_nxt;
  logic [15:0]       tally_r, tally_nxt;
  logic [15:0]       tempo_r, tempo_nxt;
  logic [IV_W-1:0]   avg_r, avg_nxt;

  // Per-item flags
  logic stored_r, stored_nxt;
  logic restart_r, restart_nxt;
  logic pulse_r, pulse_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      out_free;

  // Tap evaluation
  logic [31:0]       iv;
  logic              gap;
  logic              outlier;
  logic              usable;
  logic [FILL_W-1:0] base_fill;
  logic [SLOT_W-1:0] base_slot;
  logic [SUM_W-1:0]  base_sum;
  logic              full;
  logic [SUM_W-1:0]  new_sum;
  logic [FILL_W-1:0] new_fill;
  logic [SLOT_W-1:0] new_slot;
  logic              ring_we;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_gap_r  <= IDLE_GAP_RST;
      solid_thr_r <= SOLID_THR_RST;
      pulse_w_r   <= PULSE_WIDTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDLE_GAP:    idle_gap_r  <= cfg_data;
        CFG_SOLID_THR:   solid_thr_r <= cfg_data[3:0];
        CFG_PULSE_WIDTH: pulse_w_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tap interval checks against the window as it stands
  always_comb begin
    iv        = cur_r.now_ms - last_r;
    gap       = (iv > {16'd0, idle_gap_r});
    base_fill = gap ? '0 : fill_r;
    outlier   = (base_fill != '0) &&
                (({1'b0, iv} > {20'd0, avg_r, 1'b0}) ||
                 ({iv, 1'b0} < {21'd0, avg_r}));
    usable    = (iv > MIN_IV_MS) && (iv < MAX_IV_MS) && !outlier;
    if (gap || outlier) begin
      base_fill = '0;
      base_slot = '0;
      base_sum  = '0;
    end else begin
      base_slot = slot_r;
      base_sum  = sum_r;
    end
    full     = (base_fill == FILL_W'(WINDOW_DEPTH));
    new_sum  = base_sum - (full ? SUM_W'(ring_r[base_slot]) : '0) + SUM_W'(iv[IV_W-1:0]);
    new_fill = full ? base_fill : base_fill + 1'b1;
    new_slot = (base_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : base_slot + 1'b1;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    last_nxt      = last_r;
    tap_valid_nxt = tap_valid_r;
    tally_nxt     = tally_r;
    tempo_nxt     = tempo_r;
    avg_nxt       = avg_r;
    stored_nxt    = stored_r;
    restart_nxt   = restart_r;
    pulse_nxt     = pulse_r;
    ring_we       = 1'b0;
    div_req       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          stored_nxt  = 1'b0;
          restart_nxt = 1'b0;
          pulse_nxt   = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (cur_r.opcode)
          OP_TAP: begin
            if (tap_valid_r) begin
              restart_nxt = gap || outlier;
              if (gap || outlier) begin
                fill_nxt = '0;
                slot_nxt = '0;
                sum_nxt  = '0;
                avg_nxt  = '0;
              end
              if (usable) begin
                ring_we          = 1'b1;
                sum_nxt          = new_sum;
                fill_nxt         = new_fill;
                slot_nxt         = new_slot;
                stored_nxt       = 1'b1;
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(new_sum);
                div_req.divisor  = DSR_W'(new_fill);
                state_nxt        = ST_AVG;
              end
            end
            last_nxt      = cur_r.now_ms;
            tap_valid_nxt = 1'b1;
            if (tap_valid_r && gap) begin
              tally_nxt = 16'd1;
            end else if (tally_r != 16'hFFFF) begin
              tally_nxt = tally_r + 16'd1;
            end
          end
          OP_QUERY: begin
            if ((avg_r != '0) && tap_valid_r) begin
              div_req.start    = 1'b1;
              div_req.dividend = cur_r.now_ms - last_r;
              div_req.divisor  = avg_r;
              state_nxt        = ST_QRY;
            end
          end
          OP_CLEAR: begin
            fill_nxt      = '0;
            slot_nxt      = '0;
            sum_nxt       = '0;
            avg_nxt       = '0;
            last_nxt      = '0;
            tap_valid_nxt = 1'b0;
            tally_nxt     = '0;
          end
          OP_NONE: ;
          default: ;
        endcase
      end

      // Average known, start tempo = numerator / average
      ST_AVG: begin
        if (div_rsp.done) begin
          avg_nxt          = div_rsp.quotient[IV_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = TEMPO_NUM;
          div_req.divisor  = div_rsp.quotient[DSR_W-1:0];
          state_nxt        = ST_TEMPO;
        end
      end

      ST_TEMPO: begin
        if (div_rsp.done) begin
          tempo_nxt = div_rsp.quotient[15:0];
          state_nxt = ST_DONE;
        end
      end

      // Phase within the beat period
      ST_QRY: begin
        if (div_rsp.done) begin
          pulse_nxt = ({4'd0, div_rsp.remainder} < pulse_w_r);
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt                    = 1'b1;
          out_item_nxt.sample_stored       = stored_r;
          out_item_nxt.window_restarted    = restart_r;
          out_item_nxt.average_interval_ms = avg_r;
          out_item_nxt.tempo_centi_bpm     = tempo_r;
          out_item_nxt.stored_count        = 4'(fill_r);
          out_item_nxt.tempo_solid         = (fill_r >= solid_thr_r);
          out_item_nxt.taps_seen           = tally_r;
          out_item_nxt.beat_pulse          = pulse_r;
          state_nxt                        = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      last_r      <= '0;
      tap_valid_r <= 1'b0;
      tally_r     <= '0;
      tempo_r     <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      last_r      <= last_nxt;
      tap_valid_r <= tap_valid_nxt;
      tally_r     <= tally_nxt;
      tempo_r     <= tempo_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    stored_r   <= stored_nxt;
    restart_r  <= restart_nxt;
    pulse_r    <= pulse_nxt;
    out_item_r <= out_item_nxt;
  end

  // Interval ring, only read once every slot has been written
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_r[base_slot] <= iv[IV_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/tap_tempo_estimator_core.sv]
// ----------------------------------------------------------------------------
// tap_tempo_estimator_core
// Tap tempo estimator: moving average of tap intervals, held tempo, beat pulse.
// ----------------------------------------------------------------------------
// A tap that stores an interval makes two 32-step passes of the shared
// divider (average, then tempo), a beat query at most one, and other taps,
// clears and unused codes none; out_stall holds back the result register.
// One item is executed at a time; the front FIFO takes up to two more
// meanwhile. Synchronous active-low reset clears the control and estimator
// state except the interval ring, and loads the register defaults.
// ----------------------------------------------------------------------------
module tap_tempo_estimator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tte_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tte_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import tte_pkg::*;

  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  tte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
